[sv/sca_pkg.sv]
`timescale 1ns / 1ps
package sca_pkg;

    localparam int CLASS_SLOTS = 8;
    localparam int EXT_W       = 18;

    localparam logic [2:0] REG_POOL  = 3'd6;
    localparam logic [2:0] REG_ALIGN = 3'd7;

    typedef enum logic [1:0] {
        FUNC_GET  = 2'd0,
        FUNC_PUT  = 2'd1,
        FUNC_INFO = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_TOO_LARGE = 3'd1,
        STAT_NO_ROOM   = 3'd2,
        STAT_NOT_POOL  = 3'd3,
        STAT_NOT_ALLOC = 3'd4,
        STAT_BAD_DESC  = 3'd5
    } status_t;

    typedef struct packed {
        logic [CLASS_SLOTS-1:0][14:0] class_size;
        logic [14:0]                  pool_bytes;
        logic [3:0]                   align_log2;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [14:0] block_size;
        logic [13:0] granted_addr;
        logic [14:0] free_bytes;
        logic [15:0] new_block_count;
        logic [15:0] check_error_count;
    } res_t;

    typedef struct packed {
        logic       ok;
        logic [2:0] idx;
    } cls_t;

    // Last class in stored order that still holds sz; stop at first miss.
    function automatic cls_t class_of(logic [CLASS_SLOTS-1:0][14:0] cs, int unsigned n,
                                      logic [15:0] sz);
        cls_t r;
        logic run;
        r.ok  = (sz <= {1'b0, cs[0]});
        r.idx = 3'd0;
        run   = 1'b1;
        for (int k = 1; k < CLASS_SLOTS; k++) begin
            if (run && (k < n) && (sz <= {1'b0, cs[k]})) begin
                r.idx = 3'(k);
            end else begin
                run = 1'b0;
            end
        end
        return r;
    endfunction

endpackage

[sv/size_class_pool_allocator.sv]
`timescale 1ns / 1ps
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  tuser: func; tdata: req_size, buf_addr
// m_        out  m_tvalid/m_tready  tuser: status; tdata: size, addr, free, counters
// cfg_      in   cfg_we             cfg_addr selects register, cfg_wdata value
//
// Per request: descriptor read, then modify and write back, before the next is taken.
// After reset a clearing pass writes every descriptor with s_tready low; configuration
// writes are taken throughout.
// A full output register holds the next result in the write-back cycle until m_tready.
module size_class_pool_allocator
    import sca_pkg::*;
#(
    parameter int NUM_CLASSES    = 6,
    parameter int POOL_MAX_BYTES = 16384,
    parameter int HEADER_BYTES   = 64,
    parameter int DESC_BYTES     = 16,
    parameter int GRANULE_BYTES  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // req_size[15:0], buf_addr[29:16], zero pad
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // block_size[14:0], granted_addr[28:15],
                                   // free_bytes[43:29], new_block_count[59:44],
                                   // check_error_count[75:60], zero pad
    output logic [2:0]  m_tuser,   // status[2:0]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [14:0] cfg_wdata
);

    cfg_t cfg_reg;
    logic m_tvalid_reg;
    res_t out_reg;
    res_t res;
    logic res_valid, res_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.class_size <= {15'd0, 15'd0, 15'd32, 15'd64,
                                   15'd128, 15'd256, 15'd512, 15'd1024};
            cfg_reg.pool_bytes <= 15'd16384;
            cfg_reg.align_log2 <= 4'd4;
        end else if (cfg_we) begin
            if (cfg_addr == REG_POOL) begin
                cfg_reg.pool_bytes <= cfg_wdata;
            end else if (cfg_addr == REG_ALIGN) begin
                cfg_reg.align_log2 <= cfg_wdata[3:0];
            end else begin
                cfg_reg.class_size[cfg_addr] <= cfg_wdata;
            end
        end
    end

    sca_core #(
        .NUM_CLASSES    (NUM_CLASSES),
        .POOL_MAX_BYTES (POOL_MAX_BYTES),
        .HEADER_BYTES   (HEADER_BYTES),
        .DESC_BYTES     (DESC_BYTES),
        .GRANULE_BYTES  (GRANULE_BYTES)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req_func  (s_tuser),
        .req_size  (s_tdata[15:0]),
        .req_addr  (s_tdata[29:16]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {4'd0, out_reg.check_error_count, out_reg.new_block_count,
                       out_reg.free_bytes, out_reg.granted_addr, out_reg.block_size};

endmodule

[sv/sca_ram.sv]
`timescale 1ns / 1ps
module sca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/sca_core.sv]
`timescale 1ns / 1ps
module sca_core
    import sca_pkg::*;
#(
    parameter int NUM_CLASSES    = 6,
    parameter int POOL_MAX_BYTES = 16384,
    parameter int HEADER_BYTES   = 64,
    parameter int DESC_BYTES     = 16,
    parameter int GRANULE_BYTES  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [1:0]  req_func,
    input  logic [15:0] req_size,
    input  logic [13:0] req_addr,
    output logic        res_valid,
    input  logic        res_ready,
    output res_t        res
);

    localparam int DEPTH  = POOL_MAX_BYTES / GRANULE_BYTES;
    localparam int DW     = $clog2(DEPTH);
    localparam int GLOG   = $clog2(GRANULE_BYTES);
    localparam int CW     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    // descriptor word: next | next_ok | size | alloc | valid
    localparam int B_VAL  = 0;
    localparam int B_ALC  = 1;
    localparam int SZ_LO  = 2;
    localparam int SZ_HI  = 16;
    localparam int B_NOK  = 17;
    localparam int NX_LO  = 18;
    localparam int DESC_W = NX_LO + DW;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [DW-1:0]   clr_reg;
    logic [1:0]      func_reg;
    logic [CW-1:0]   cls_reg;
    logic            cls_ok_reg;
    logic            pop_reg;
    logic [2:0]      loc_reg;
    logic [DW-1:0]   idx_reg;
    logic [14:0]     bump_reg, bump_next;
    logic [15:0]     newc_reg, newc_next;
    logic [15:0]     chk_reg, chk_next;
    logic [DW-1:0]   top_idx_reg [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] top_ok_reg;

    logic            accept, go;
    cls_t            cls_now, cls_put;
    logic [CW-1:0]   cls_now_i;
    logic [EXT_W-1:0] pend, addr_x, a_x, mask_x;
    logic [2:0]      loc_now;
    logic [DW-1:0]   raddr, waddr;
    logic            re, we;
    logic [DESC_W-1:0] rd, wd;
    logic [3:0]      alg;
    logic            top_we, top_ok_n;
    logic [CW-1:0]   top_cls;
    logic [DW-1:0]   top_idx_n;
    logic [2:0]      status;
    logic [14:0]     bsize;
    logic [13:0]     granted;

    assign accept    = req_valid && req_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign go        = (state_reg == S_EXEC) && res_ready;
    assign res_valid = (state_reg == S_EXEC);

    assign pend = (cfg.pool_bytes < 15'(POOL_MAX_BYTES))
                  ? EXT_W'(cfg.pool_bytes) : EXT_W'(POOL_MAX_BYTES);

    assign cls_now   = class_of(cfg.class_size, NUM_CLASSES, req_size);
    assign cls_now_i = cls_now.idx[CW-1:0];

    // Range and granule checks; descriptor bits come after the read.
    assign addr_x = EXT_W'(req_addr);
    always_comb begin
        if (addr_x < EXT_W'(HEADER_BYTES + DESC_BYTES) || addr_x >= pend) begin
            loc_now = STAT_NOT_POOL;
        end else if ((addr_x & EXT_W'(GRANULE_BYTES - 1)) != '0 ||
                     (addr_x >> GLOG) >= EXT_W'(DEPTH)) begin
            loc_now = STAT_BAD_DESC;
        end else begin
            loc_now = STAT_OK;
        end
    end

    assign re    = accept;
    assign raddr = (req_func == FUNC_GET) ? top_idx_reg[cls_now_i] : DW'(addr_x >> GLOG);

    sca_ram #(.WIDTH(DESC_W), .DEPTH(DEPTH)) u_desc (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wd),
        .re    (re),
        .raddr (raddr),
        .rdata (rd)
    );

    always_comb begin
        alg = (cfg.align_log2 > 4'd14) ? 4'd14 : cfg.align_log2;
        if (alg < 4'(GLOG)) begin
            alg = 4'(GLOG);
        end
        mask_x = (EXT_W'(1) << alg) - EXT_W'(1);
    end

    assign a_x     = (EXT_W'(bump_reg) + EXT_W'(DESC_BYTES) + mask_x) & ~mask_x;
    assign cls_put = class_of(cfg.class_size, NUM_CLASSES, {1'b0, rd[SZ_HI:SZ_LO]});

    always_comb begin
        status    = STAT_OK;
        bsize     = '0;
        granted   = '0;
        bump_next = bump_reg;
        newc_next = newc_reg;
        chk_next  = chk_reg;
        we        = 1'b0;
        waddr     = idx_reg;
        wd        = rd;
        top_we    = 1'b0;
        top_cls   = cls_reg;
        top_idx_n = idx_reg;
        top_ok_n  = 1'b1;
        if (state_reg == S_CLEAR) begin
            we    = 1'b1;
            waddr = clr_reg;
            wd    = '0;
        end else begin
            case (func_reg)
                FUNC_GET: begin
                    if (!cls_ok_reg) begin
                        status = STAT_TOO_LARGE;
                    end else if (pop_reg) begin
                        bsize     = cfg.class_size[cls_reg];
                        granted   = 14'(EXT_W'(idx_reg) << GLOG);
                        we        = go;
                        wd        = rd;
                        wd[B_VAL] = 1'b1;
                        wd[B_ALC] = 1'b1;
                        wd[SZ_HI:SZ_LO] = bsize;
                        wd[B_NOK] = 1'b0;
                        top_we    = go;
                        top_idx_n = rd[DESC_W-1:NX_LO];
                        top_ok_n  = rd[B_NOK];
                    end else if ((a_x + EXT_W'(cfg.class_size[cls_reg])) > pend ||
                                 a_x >= pend || (a_x >> GLOG) >= EXT_W'(DEPTH)) begin
                        status = STAT_NO_ROOM;
                    end else begin
                        bsize     = cfg.class_size[cls_reg];
                        granted   = a_x[13:0];
                        bump_next = 15'(a_x + EXT_W'(bsize));
                        newc_next = newc_reg + 16'd1;
                        we        = go;
                        waddr     = DW'(a_x >> GLOG);
                        wd        = '0;
                        wd[B_VAL] = 1'b1;
                        wd[B_ALC] = 1'b1;
                        wd[SZ_HI:SZ_LO] = bsize;
                    end
                end
                FUNC_PUT: begin
                    if (loc_reg != STAT_OK) begin
                        status = loc_reg;
                    end else if (!rd[B_VAL]) begin
                        status = STAT_BAD_DESC;
                    end else if (!rd[B_ALC]) begin
                        status = STAT_NOT_ALLOC;
                    end else if (!cls_put.ok) begin
                        status = STAT_BAD_DESC;
                    end else begin
                        top_cls   = cls_put.idx[CW-1:0];
                        bsize     = cfg.class_size[top_cls];
                        we        = go;
                        wd        = rd;
                        wd[B_ALC] = 1'b0;
                        wd[B_NOK] = top_ok_reg[top_cls];
                        wd[DESC_W-1:NX_LO] = top_idx_reg[top_cls];
                        top_we    = go;
                        top_idx_n = idx_reg;
                        top_ok_n  = 1'b1;
                    end
                    if (status == STAT_NOT_ALLOC || status == STAT_BAD_DESC) begin
                        chk_next = chk_reg + 16'd1;
                    end
                end
                default: begin
                    if (loc_reg != STAT_OK) begin
                        status = loc_reg;
                    end else if (!rd[B_VAL]) begin
                        status = STAT_BAD_DESC;
                    end else if (!rd[B_ALC]) begin
                        status = STAT_NOT_ALLOC;
                    end else begin
                        bsize = rd[SZ_HI:SZ_LO];
                    end
                end
            endcase
        end
    end

    always_comb begin
        res.status            = status;
        res.block_size        = bsize;
        res.granted_addr      = granted;
        res.free_bytes        = (pend > EXT_W'(bump_next))
                                ? 15'(pend - EXT_W'(bump_next)) : 15'd0;
        res.new_block_count   = newc_next;
        res.check_error_count = chk_next;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (clr_reg == DW'(DEPTH - 1)) state_next = S_IDLE;
            S_IDLE:  if (accept) state_next = S_EXEC;
            S_EXEC:  if (go) state_next = S_IDLE;
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            bump_reg   <= 15'(HEADER_BYTES);
            newc_reg   <= '0;
            chk_reg    <= '0;
            top_ok_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) begin
                clr_reg <= clr_reg + DW'(1);
            end
            if (go) begin
                bump_reg <= bump_next;
                newc_reg <= newc_next;
                chk_reg  <= chk_next;
                if (top_we) begin
                    top_ok_reg[top_cls] <= top_ok_n;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg   <= req_func;
            cls_reg    <= cls_now_i;
            cls_ok_reg <= cls_now.ok;
            pop_reg    <= top_ok_reg[cls_now_i];
            loc_reg    <= loc_now;
            idx_reg    <= raddr;
        end
        if (go && top_we) begin
            top_idx_reg[top_cls] <= top_idx_n;
        end
    end

endmodule

[verif/tb_size_class_pool_allocator.sv]
`timescale 1ns / 1ps
module tb_size_class_pool_allocator;
    import sca_pkg::*;

    localparam int NCLS      = 6;
    localparam int POOL_MAX  = 16384;
    localparam int HDR       = 64;
    localparam int DGAP      = 16;
    localparam int GRAN      = 16;
    localparam int NDESC     = POOL_MAX / GRAN;
    localparam int MAX_CYCLES = 2000000;

    class alloc_scoreboard;
        int unsigned cls_size[CLASS_SLOTS];
        int unsigned pool_len;
        int unsigned align_exp;
        bit          dv[NDESC];
        bit          da[NDESC];
        int unsigned dsz[NDESC];
        int unsigned dnext[NDESC];
        bit          dnext_ok[NDESC];
        int unsigned stk_top[CLASS_SLOTS];
        bit          stk_ok[CLASS_SLOTS];
        int unsigned bump;
        int unsigned carved;
        int unsigned bad_puts;
        res_t        pending[$];
        int          errors;

        function new();
            for (int i = 0; i < CLASS_SLOTS; i++) begin
                cls_size[i] = 0;
                stk_ok[i]   = 0;
                stk_top[i]  = 0;
            end
            for (int k = 0; k < NDESC; k++) begin
                dv[k] = 0; da[k] = 0; dsz[k] = 0; dnext[k] = 0; dnext_ok[k] = 0;
            end
            bump = HDR; carved = 0; bad_puts = 0; errors = 0;
        endfunction

        function int unsigned pool_end();
            return (pool_len < POOL_MAX) ? pool_len : POOL_MAX;
        endfunction

        function int size_class(int unsigned sz);
            int i;
            i = 0;
            if (sz > cls_size[0]) return -1;
            while (i + 1 < NCLS && sz <= cls_size[i + 1]) i++;
            return i;
        endfunction

        function int unsigned align_mask();
            int unsigned a;
            int unsigned al;
            a  = (align_exp > 14) ? 14 : align_exp;
            al = 1 << a;
            while (al < GRAN) al = al << 1;
            return al - 1;
        endfunction

        function status_t find_desc(int unsigned addr, output int unsigned idx);
            idx = 0;
            if (addr < HDR + DGAP || addr >= pool_end()) return STAT_NOT_POOL;
            if ((addr % GRAN) != 0 || addr / GRAN >= NDESC) return STAT_BAD_DESC;
            idx = addr / GRAN;
            if (!dv[idx]) return STAT_BAD_DESC;
            if (!da[idx]) return STAT_NOT_ALLOC;
            return STAT_OK;
        endfunction

        // Predict the result of one accepted request and queue it.
        function res_t note_request(logic [1:0] fn, int unsigned req, int unsigned addr);
            res_t        r;
            status_t     st;
            int          c;
            int unsigned idx, bsz, grant, m, a, e;
            st = STAT_OK; bsz = 0; grant = 0; idx = 0;
            if (fn == FUNC_GET) begin
                c = size_class(req);
                if (c < 0) begin
                    st = STAT_TOO_LARGE;
                end else if (stk_ok[c]) begin
                    idx = stk_top[c];
                    stk_ok[c]  = dnext_ok[idx];
                    stk_top[c] = dnext[idx];
                    bsz = cls_size[c];
                    dv[idx] = 1; da[idx] = 1; dsz[idx] = bsz; dnext_ok[idx] = 0;
                    grant = idx * GRAN;
                end else begin
                    m   = align_mask();
                    a   = (bump + DGAP + m) & ~m;
                    bsz = cls_size[c];
                    e   = pool_end();
                    if (a + bsz > e || a >= e || a / GRAN >= NDESC) begin
                        st = STAT_NO_ROOM; bsz = 0;
                    end else begin
                        idx  = a / GRAN;
                        bump = a + bsz;
                        carved = (carved + 1) & 16'hffff;
                        dv[idx] = 1; da[idx] = 1; dsz[idx] = bsz; dnext_ok[idx] = 0;
                        grant = a;
                    end
                end
            end else if (fn == FUNC_PUT) begin
                st = find_desc(addr, idx);
                if (st == STAT_OK) begin
                    c = size_class(dsz[idx]);
                    if (c < 0) begin
                        st = STAT_BAD_DESC;
                    end else begin
                        bsz = cls_size[c];
                        da[idx] = 0;
                        dnext[idx] = stk_top[c];
                        dnext_ok[idx] = stk_ok[c];
                        stk_top[c] = idx;
                        stk_ok[c] = 1;
                    end
                end
                if (st == STAT_NOT_ALLOC || st == STAT_BAD_DESC)
                    bad_puts = (bad_puts + 1) & 16'hffff;
            end else begin
                st = find_desc(addr, idx);
                if (st == STAT_OK) bsz = dsz[idx];
            end
            e = pool_end();
            r.status            = st;
            r.block_size        = bsz[14:0];
            r.granted_addr      = grant[13:0];
            r.free_bytes        = (e > bump) ? 15'(e - bump) : 15'd0;
            r.new_block_count   = carved[15:0];
            r.check_error_count = bad_puts[15:0];
            pending.push_back(r);
            return r;
        endfunction

        function void check_result(res_t got);
            res_t x;
            if (pending.size() == 0) begin
                $error("result with nothing expected: status %0d", got.status);
                errors++;
                return;
            end
            x = pending.pop_front();
            if (got.status != x.status) begin
                $error("status exp %0d got %0d", x.status, got.status); errors++;
            end
            if (got.block_size != x.block_size) begin
                $error("block_size exp %0d got %0d", x.block_size, got.block_size); errors++;
            end
            if (got.granted_addr != x.granted_addr) begin
                $error("granted_addr exp %0d got %0d", x.granted_addr, got.granted_addr);
                errors++;
            end
            if (got.free_bytes != x.free_bytes) begin
                $error("free_bytes exp %0d got %0d", x.free_bytes, got.free_bytes); errors++;
            end
            if (got.new_block_count != x.new_block_count) begin
                $error("new_block_count exp %0d got %0d", x.new_block_count,
                       got.new_block_count);
                errors++;
            end
            if (got.check_error_count != x.check_error_count) begin
                $error("check_error_count exp %0d got %0d", x.check_error_count,
                       got.check_error_count);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [14:0] cfg_wdata;

    alloc_scoreboard sb;
    int unsigned     tx_idle_pct;
    int unsigned     rx_idle_pct;
    int unsigned     cycles;
    int unsigned     live[$];

    size_class_pool_allocator u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready = ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        res_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.status            = m_tuser;
            got.block_size        = m_tdata[14:0];
            got.granted_addr      = m_tdata[28:15];
            got.free_bytes        = m_tdata[43:29];
            got.new_block_count   = m_tdata[59:44];
            got.check_error_count = m_tdata[75:60];
            sb.check_result(got);
        end
    end

    task automatic write_reg(logic [2:0] idx, int unsigned val);
        @(negedge aclk);
        cfg_we = 1'b1; cfg_addr = idx; cfg_wdata = val[14:0];
        @(negedge aclk);
        cfg_we = 1'b0;
        if (idx < NCLS) sb.cls_size[idx] = val & 16'h7fff;
        else if (idx == REG_POOL) sb.pool_len = val & 16'h7fff;
        else sb.align_exp = val & 4'hf;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic apply_config(int unsigned c0, c1, c2, c3, c4, c5, pl, al);
        drain();
        write_reg(3'd0, c0); write_reg(3'd1, c1); write_reg(3'd2, c2);
        write_reg(3'd3, c3); write_reg(3'd4, c4); write_reg(3'd5, c5);
        write_reg(REG_POOL, pl); write_reg(REG_ALIGN, al);
    endtask

    // Drive one request and hold it until the transfer.
    task automatic send(logic [1:0] fn, int unsigned req, int unsigned addr);
        res_t r;
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = fn;
        s_tdata  = {2'b00, addr[13:0], req[15:0]};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        r = sb.note_request(fn, req, addr);
        if (fn == FUNC_GET && r.status == STAT_OK) live.push_back(r.granted_addr);
        if (fn == FUNC_PUT && r.status == STAT_OK) begin
            foreach (live[i]) if (live[i] == addr) begin
                live.delete(i);
                break;
            end
        end
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic random_items(int n);
        int unsigned sel, req, addr, k;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(99);
            if (live.size() > 40 && sel < 45) sel = sel + 45;
            if (sel < 45) begin
                if ($urandom_range(9) == 0) req = $urandom_range(16'hffff);
                else req = $urandom_range(sb.cls_size[0] + 8);
                send(FUNC_GET, req, $urandom_range(16'h3fff));
            end else if (sel < 78 && live.size() > 0) begin
                k = $urandom_range(live.size() - 1);
                send(FUNC_PUT, $urandom_range(16'hffff), live[k]);
            end else if (sel < 88 && live.size() > 0) begin
                k = $urandom_range(live.size() - 1);
                addr = live[k];
                // misaligned or stale neighbor now and then
                if ($urandom_range(3) == 0) addr = addr + $urandom_range(1, 31);
                send(logic'($urandom_range(1)) ? FUNC_PUT : FUNC_INFO,
                     $urandom_range(16'hffff), addr & 16'h3fff);
            end else begin
                send(2'($urandom_range(3)), $urandom_range(16'hffff),
                     $urandom_range(16'h3fff));
            end
            if (i == n / 2 && $urandom_range(1)) drain();
        end
    endtask

    initial begin
        sb = new();
        cycles = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0; cfg_addr = '0; cfg_wdata = '0;
        tx_idle_pct = 17; rx_idle_pct = 76;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        apply_config(1024, 512, 256, 128, 64, 32, 16384, 4);
        send(FUNC_GET, 0, 0);
        send(FUNC_GET, 1024, 0);
        send(FUNC_GET, 1025, 0);
        send(FUNC_GET, 16'hffff, 0);
        send(FUNC_GET, 33, 16'h3fff);
        send(FUNC_INFO, 0, live[0]);
        send(2'd3, 16'hffff, live[1]);
        send(FUNC_PUT, 0, live[0]);
        send(FUNC_PUT, 0, 96 + 1024 + 16);
        send(FUNC_PUT, 0, 0);
        send(FUNC_PUT, 0, 79);
        send(FUNC_PUT, 0, 16383);
        send(FUNC_PUT, 0, 16'h3ff0);
        send(FUNC_PUT, 0, live[0] + 8);
        send(FUNC_GET, 1000, 0);
        send(FUNC_PUT, 0, 96);
        send(FUNC_PUT, 0, 96);
        send(FUNC_INFO, 0, 96);
        send(FUNC_GET, 64, 0);

        random_items(250);
        apply_config(16384, 4096, 1024, 256, 64, 16, 16384, 8);
        random_items(250);
        tx_idle_pct = 76; rx_idle_pct = 17;
        apply_config(2048, 512, 0, 0, 0, 0, 16384, 5);
        random_items(250);
        apply_config(64, 32, 16, 0, 0, 0, 128, 4);
        random_items(250);
        apply_config($urandom_range(16384), $urandom_range(16384), $urandom_range(16384),
                     $urandom_range(16384), $urandom_range(16384), $urandom_range(16384),
                     $urandom_range(128, 16384), $urandom_range(4, 8));
        random_items(250);
        tx_idle_pct = 0; rx_idle_pct = 0;
        apply_config(1024, 512, 256, 128, 64, 32, 16384, 6);
        random_items(250);
        apply_config(4096, 2048, 300, 1000, 48, 0, $urandom_range(128, 16384), 7);
        random_items(250);

        drain();
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
